FILE: sv/swse_pkg.sv
// Shared constants and types for the sliding-window sum and absolute-sum block.
package swse_pkg;

  localparam int DEPTH    = 32;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int SAMPLE_W = 16;
  localparam int WLEN_W   = 6;
  localparam int SUM_W    = 21;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(32);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_LAST,
    ST_DONE
  } state_t;

endpackage

FILE: sv/swse_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module swse_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/sample_window_sum_and_energy.sv
// Top level of the sliding-window sum and absolute-sum block.
//
//   Channel   Signals                           Direction  Beat contents
//   --------  --------------------------------  ---------  -------------------------------
//   input     in_valid, in_ready, sample        in         one signed 16-bit sample
//   output    out_valid, out_ready, window_sum,  out        signed sum and absolute sum
//             window_abs_sum
//   config    cfg_we, cfg_wdata                  in         window length (6 bits)
//
// An accepted sample is written into the sample RAM in the cycle it arrives. The window
// is then read back one entry per cycle through the RAM's single read port, newest first,
// so a beat reads as many entries as the window length, limited to the line depth of 32,
// before its result sits in the output register; a window length of zero reads no entries.
// Reset is synchronous and marks every RAM entry as empty; an empty entry reads as zero,
// so no clearing pass is needed. The output register lets the next sample be accepted
// while a result is still waiting; a stalled output only holds the block at the end of
// the following beat's accumulation.
module sample_window_sum_and_energy (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [swse_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [swse_pkg::SUM_W-1:0]    window_sum,
  output logic        [swse_pkg::SUM_W-1:0]    window_abs_sum,
  input  logic                                cfg_we,
  input  logic        [swse_pkg::WLEN_W-1:0]   cfg_wdata
);

  swse_pkg::state_t state, state_next;

  logic [swse_pkg::WLEN_W-1:0] window_len;
  logic [swse_pkg::ADDR_W-1:0] pos;
  logic [swse_pkg::ADDR_W-1:0] pos_inc;
  logic [swse_pkg::ADDR_W-1:0] k;
  logic [swse_pkg::ADDR_W-1:0] rd_addr;
  logic [swse_pkg::ADDR_W:0]   rd_diff;
  logic [swse_pkg::CNT_W-1:0]  cnt;
  logic [swse_pkg::CNT_W-1:0]  cnt_clamped;
  logic [swse_pkg::DEPTH-1:0]  line_valid;
  logic                        rd_pend;
  logic                        rd_ok;
  logic                        accept;
  logic                        issue;
  logic                        load_out;
  logic                        last_read;

  logic signed [swse_pkg::SAMPLE_W-1:0] rdata;
  logic signed [swse_pkg::SAMPLE_W-1:0] rd_val;
  logic signed [swse_pkg::SUM_W-1:0]    val_ext;
  logic        [swse_pkg::SUM_W-1:0]    val_abs;
  logic signed [swse_pkg::SUM_W-1:0]    acc_sum;
  logic        [swse_pkg::SUM_W-1:0]    acc_abs;

  // The oldest entry sits just after the newest one, so the new sample goes there.
  assign pos_inc = (int'(pos) == swse_pkg::DEPTH - 1) ? '0 : pos + 1'b1;

  // Windows longer than the line are limited to the line's depth.
  assign cnt_clamped = (int'(window_len) > swse_pkg::DEPTH) ?
                       swse_pkg::CNT_W'(swse_pkg::DEPTH) :
                       swse_pkg::CNT_W'(window_len);

  // Entry k steps back from the newest one, wrapping around the line.
  assign rd_diff = {1'b0, pos} - {1'b0, k};
  assign rd_addr = rd_diff[swse_pkg::ADDR_W] ?
                   swse_pkg::ADDR_W'(rd_diff + (swse_pkg::ADDR_W+1)'(swse_pkg::DEPTH)) :
                   rd_diff[swse_pkg::ADDR_W-1:0];

  assign last_read = (swse_pkg::CNT_W'(k) + swse_pkg::CNT_W'(1)) == cnt;
  assign accept    = in_valid && in_ready;

  // An entry never written since reset counts as zero.
  assign rd_val  = rd_ok ? rdata : '0;
  assign val_ext = swse_pkg::SUM_W'(rd_val);
  assign val_abs = rd_val[swse_pkg::SAMPLE_W-1] ? swse_pkg::SUM_W'(-val_ext) :
                                                 swse_pkg::SUM_W'(val_ext);

  swse_ram #(
    .WIDTH(swse_pkg::SAMPLE_W),
    .DEPTH(swse_pkg::DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (accept),
    .waddr(pos_inc),
    .wdata(sample),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Reads never overlap the write of the same beat: the write happens on acceptance
  // and the first read is issued in the following cycle.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      swse_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (cnt_clamped == '0) ? swse_pkg::ST_DONE : swse_pkg::ST_SUM;
        end
      end
      swse_pkg::ST_SUM: begin
        issue = 1'b1;
        if (last_read) begin
          state_next = swse_pkg::ST_LAST;
        end
      end
      swse_pkg::ST_LAST: begin
        state_next = swse_pkg::ST_DONE;
      end
      swse_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = swse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = swse_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= swse_pkg::WLEN_RESET;
      pos        <= '0;
      line_valid <= '0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len <= cfg_wdata;
      end
      if (accept) begin
        pos                 <= pos_inc;
        line_valid[pos_inc] <= 1'b1;
      end
      rd_pend <= issue;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath: read counter, accumulators and output register.
  always_ff @(posedge clk) begin
    rd_ok <= line_valid[rd_addr];
    if (accept) begin
      k       <= '0;
      cnt     <= cnt_clamped;
      acc_sum <= '0;
      acc_abs <= '0;
    end else begin
      if (issue) begin
        k <= k + 1'b1;
      end
      if (rd_pend) begin
        acc_sum <= acc_sum + val_ext;
        acc_abs <= acc_abs + val_abs;
      end
    end
    if (load_out) begin
      window_sum     <= acc_sum;
      window_abs_sum <= acc_abs;
    end
  end

endmodule

FILE: dv/sample_window_sum_and_energy_tb.sv
// Self-checking testbench for the sliding-window sum and absolute-sum block.
`timescale 1ns / 100ps

module sample_window_sum_and_energy_tb;

  localparam int DEPTH    = swse_pkg::DEPTH;
  localparam int SAMPLE_W = swse_pkg::SAMPLE_W;
  localparam int WLEN_W   = swse_pkg::WLEN_W;
  localparam int SUM_W    = swse_pkg::SUM_W;

  // The longest beat reads the full window, so this many idle cycles after the last
  // result leave the block quiet before a register write.
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRINT_LIMIT    = 100;
  localparam int RANDOM_PHASES  = 10;
  localparam int ITEMS_PER_PHASE = 90;

  // Predicts both sums for every accepted sample and checks result beats in order.
  // It keeps its own copy of the delay line, the newest pointer and the window length.
  class window_sum_scoreboard;
    logic signed [SAMPLE_W-1:0] line_copy [DEPTH];
    int unsigned                newest;
    logic [WLEN_W-1:0]          wlen;
    logic signed [SUM_W-1:0]    expected_sums [$];
    logic [SUM_W-1:0]           expected_abs_sums [$];
    int                         errors;
    int                         checked;

    function new();
      for (int i = 0; i < DEPTH; i++) line_copy[i] = '0;
      newest  = 0;
      wlen    = swse_pkg::WLEN_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_window(logic [WLEN_W-1:0] len);
      wlen = len;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    // The new sample overwrites the oldest entry, which sits just past the newest.
    // The window is clipped to the line depth, so a long window sums every entry once.
    function void record_sample(logic signed [SAMPLE_W-1:0] s);
      int unsigned count;
      longint      acc;
      longint      abs_acc;
      longint      v;
      newest = (newest + 1) % DEPTH;
      line_copy[newest] = s;
      count   = (wlen > DEPTH) ? DEPTH : wlen;
      acc     = 0;
      abs_acc = 0;
      for (int unsigned k = 0; k < count; k++) begin
        v = line_copy[(newest + DEPTH - k) % DEPTH];
        acc     += v;
        abs_acc += (v < 0) ? -v : v;
      end
      expected_sums.push_back(SUM_W'(acc));
      expected_abs_sums.push_back(SUM_W'(abs_acc));
    endfunction

    task report(string what, longint got, longint want);
      if (errors < PRINT_LIMIT)
        $display("%0t ns: MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_sums(logic signed [SUM_W-1:0] got_sum, logic [SUM_W-1:0] got_abs);
      logic signed [SUM_W-1:0] want_sum;
      logic [SUM_W-1:0]        want_abs;
      if (expected_sums.size() == 0) begin
        report("result beat with no sample pending", got_sum, 0);
        return;
      end
      want_sum = expected_sums.pop_front();
      want_abs = expected_abs_sums.pop_front();
      checked++;
      if (got_sum !== want_sum) report("window_sum", got_sum, want_sum);
      if (got_abs !== want_abs) report("window_abs_sum", got_abs, want_abs);
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SUM_W-1:0]    window_sum;
  logic [SUM_W-1:0]           window_abs_sum;
  logic                       cfg_we = 1'b0;
  logic [WLEN_W-1:0]          cfg_wdata = '0;

  window_sum_scoreboard sums = new();

  // Traffic shaping state. A burst flag turns off all idling on its side for a while,
  // and a run of one repeated extreme value fills the whole line so the sums hit
  // their largest magnitudes.
  bit                         sender_burst = 1'b0;
  bit                         receiver_burst = 1'b0;
  int                         run_left = 0;
  logic signed [SAMPLE_W-1:0] run_value = '0;
  int                         samples_sent = 0;
  int                         window_settings = 0;

  sample_window_sum_and_energy u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .window_sum     (window_sum),
    .window_abs_sum (window_abs_sum),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one. The burst flag
  // flips rarely so that some stretches run with no idling at all.
  function automatic int idle_length(ref bit burst);
    int r;
    if ($urandom_range(0, 99) < 3) burst = !burst;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'shFFFF;
      3: return 16'sh0001;
      default: return 16'sh0000;
    endcase
  endfunction

  // Random samples: full-range words cover every bit, extremes and small values
  // around zero stress the sign handling, and constant runs at least as long as the line
  // drive both sums to their limits.
  function automatic logic signed [SAMPLE_W-1:0] next_sample();
    int r;
    if (run_left > 0) begin
      run_left--;
      return run_value;
    end
    r = $urandom_range(0, 99);
    if (r < 6) begin
      run_value = extreme_value();
      run_left  = $urandom_range(31, 40);
      return run_value;
    end
    if (r < 25) return extreme_value();
    if (r < 40) return SAMPLE_W'($signed($urandom_range(0, 30)) - 15);
    return SAMPLE_W'($urandom_range(0, 65535));
  endfunction

  // Sender: valid is raised after an optional gap and held with a steady payload
  // until the beat is taken. Back-to-back beats keep valid high with one update.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_length(sender_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    sums.record_sample(s);
    samples_sent++;
  endtask

  // Holds the sender off until every predicted result has been checked.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sums.pending() != 0) @(posedge clk);
  endtask

  // The register is only written with nothing in flight, after the settle time.
  task automatic write_window(input logic [WLEN_W-1:0] len);
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sums.set_window(len);
    window_settings++;
  endtask

  // Receiver: ready drops for random stretches, with stall-free bursts in between.
  initial begin
    int stall;
    @(posedge clk iff !rst);
    forever begin
      stall = idle_length(receiver_burst);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Result beats are checked as they are accepted, against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sums.check_sums(window_sum, window_abs_sum);
  end

  initial begin
    logic [WLEN_W-1:0] phase_len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first beats run with the reset window of 32 and check
    // that the line starts out as zeros.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);

    // A window of zero sums nothing, whatever the sample.
    write_window(WLEN_W'(0));
    send_sample(16'sh1234);
    send_sample(16'sh8000);

    // A window of one returns the new sample and its magnitude alone.
    write_window(WLEN_W'(1));
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'shFFFF);

    // Windows past the line depth are clipped, so each entry counts once.
    write_window(WLEN_W'(63));
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    write_window(WLEN_W'(33));
    send_sample(16'sh0001);

    // Random part: each phase runs at its own window, fixed lengths covering the
    // edges first and random lengths over the full register range after that.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: phase_len = WLEN_W'(32);
        1: phase_len = WLEN_W'(1);
        2: phase_len = WLEN_W'(63);
        3: phase_len = WLEN_W'(2);
        4: phase_len = WLEN_W'(31);
        5: phase_len = WLEN_W'(0);
        6: phase_len = WLEN_W'(33);
        default: phase_len = WLEN_W'($urandom_range(0, 63));
      endcase
      write_window(phase_len);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_sample(next_sample());
        // Mid-phase, the sender stops until every result is back and then resumes.
        if (i == ITEMS_PER_PHASE / 2) wait_results_done();
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples over %0d window settings and checked %0d results.",
             samples_sent, window_settings + 1, sums.checked);
    $display("Windows included zero, one, the full line and lengths beyond it.");
    if (sums.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, every beat waiting out the
  // longest gap and stall on top of the full-window latency.
  initial begin
    #3_000_000;
    $display("Timeout waiting for the block to finish.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
